// ===== src/brmr_pkg.sv =====
// ----------------------------------------------------------------------------
// brmr_pkg
// Shared constants, codes and controller/datapath link types for the banked
// ROM mapped read block.
// ----------------------------------------------------------------------------
package brmr_pkg;

  localparam int unsigned ROM_DEPTH_DEF = 1048576;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned LOADED_W      = 21;
  localparam int unsigned FUNC_W        = 3;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CNT_W         = 3;   // holds 0..4 byte lanes
  localparam int unsigned S_TDATA_W     = 48;  // func, address, load_byte, padded
  localparam int unsigned M_TDATA_W     = 40;  // read_data, mapped, padded

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD   = 3'd0,
    FUNC_READ8  = 3'd1,
    FUNC_READ16 = 3'd2,
    FUNC_READ32 = 3'd3,
    FUNC_PROBE  = 3'd4
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIXED_BASE = 3'd0,
    CFG_FIXED_SIZE = 3'd1,
    CFG_BANK_BASE  = 3'd2,
    CFG_BANK_SIZE  = 3'd3,
    CFG_LOADED     = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_FINISH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic start;    // latch the accepted request
    logic write;    // perform the store write of a load
    logic issue;    // translate the next byte lane
    logic publish;  // move the result into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_load;     // incoming request is a load
    logic in_xfer;     // incoming request gives a result
    logic issue_more;  // byte lanes left to translate
    logic all_done;    // all byte lanes collected
    logic out_free;    // output register can take a result
  } dp_status_t;

endpackage

// ===== src/brmr_ram.sv =====
// ----------------------------------------------------------------------------
// brmr_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module brmr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/brmr_dp.sv =====
// ----------------------------------------------------------------------------
// brmr_dp
// Datapath: configuration registers, per-byte address translation pipeline,
// ROM store, big-endian assembly and output register.
// ----------------------------------------------------------------------------
module brmr_dp #(
  parameter int unsigned ROM_DEPTH = brmr_pkg::ROM_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [brmr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [brmr_pkg::WORD_W-1:0]      cfg_data_i,
  input  logic [brmr_pkg::S_TDATA_W-1:0]   s_tdata_i,
  input  logic                             m_tready_i,
  output logic                             m_tvalid_o,
  output logic [brmr_pkg::M_TDATA_W-1:0]   m_tdata_o,
  input  brmr_pkg::dp_cmd_t                cmd_i,
  output brmr_pkg::dp_status_t             status_o
);
  import brmr_pkg::*;

  localparam int unsigned AW   = $clog2(ROM_DEPTH);
  localparam int unsigned SZ_W = $clog2(ROM_DEPTH + 1);
  localparam logic [WORD_W-1:0] DEPTH_W = WORD_W'(ROM_DEPTH);

  // ---------------- configuration ----------------
  logic [WORD_W-1:0] fbase_q, fbase_d, fsize_q, fsize_d;
  logic [WORD_W-1:0] bbase_q, bbase_d, bsize_q, bsize_d;
  logic [SZ_W-1:0]   size_q, size_d;     // loaded size clamped to the store depth
  logic [WORD_W-1:0] loaded_ext;

  assign loaded_ext = WORD_W'(cfg_data_i[LOADED_W-1:0]);

  always_comb begin
    fbase_d = fbase_q;
    fsize_d = fsize_q;
    bbase_d = bbase_q;
    bsize_d = bsize_q;
    size_d  = size_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FIXED_BASE: fbase_d = cfg_data_i;
        CFG_FIXED_SIZE: fsize_d = cfg_data_i;
        CFG_BANK_BASE:  bbase_d = cfg_data_i;
        CFG_BANK_SIZE:  bsize_d = cfg_data_i;
        CFG_LOADED:     size_d  = (loaded_ext >= DEPTH_W) ? SZ_W'(DEPTH_W)
                                                          : SZ_W'(loaded_ext);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fbase_q <= '0;
      fsize_q <= '0;
      bbase_q <= '0;
      bsize_q <= '0;
      size_q  <= '0;
    end else begin
      fbase_q <= fbase_d;
      fsize_q <= fsize_d;
      bbase_q <= bbase_d;
      bsize_q <= bsize_d;
      size_q  <= size_d;
    end
  end

  // ---------------- request fields ----------------
  logic [FUNC_W-1:0] in_func;
  logic [WORD_W-1:0] in_addr;
  logic [BYTE_W-1:0] in_byte;

  assign in_func = s_tdata_i[FUNC_W-1:0];
  assign in_addr = s_tdata_i[FUNC_W +: WORD_W];
  assign in_byte = s_tdata_i[FUNC_W+WORD_W +: BYTE_W];

  logic [FUNC_W-1:0] func_q;
  logic [WORD_W-1:0] addr_q;
  logic [BYTE_W-1:0] byte_q;
  logic [CNT_W-1:0]  n_d, n_q, idx_q, got_q;
  logic              in_xfer;

  always_comb begin
    n_d     = '0;
    in_xfer = 1'b1;
    case (func_e'(in_func))
      FUNC_READ8:  n_d = CNT_W'(1);
      FUNC_READ16: n_d = CNT_W'(2);
      FUNC_READ32: n_d = CNT_W'(4);
      FUNC_PROBE:  n_d = CNT_W'(1);   // one lane for the flag, no data
      default:     in_xfer = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      func_q <= in_func;
      addr_q <= in_addr;
      byte_q <= in_byte;
    end
  end

  // ---------------- stage A: window compares ----------------
  logic [WORD_W-1:0] ba, relf, relb;
  logic [WORD_W-1:0] a_ba_q, a_relf_q, a_relb_q;
  logic              a_v_q, a_fhit_q, a_bhit_q, a_first_q;

  assign ba   = addr_q + WORD_W'(idx_q);
  assign relf = ba - fbase_q;
  assign relb = ba - bbase_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      a_ba_q    <= ba;
      a_relf_q  <= relf;
      a_relb_q  <= relb;
      a_fhit_q  <= (fsize_q != '0) && (ba >= fbase_q) && (relf < fsize_q);
      a_bhit_q  <= (bsize_q != '0) && (ba >= bbase_q) && (relb < bsize_q);
      a_first_q <= (idx_q == '0);
    end
  end

  // ---------------- stage B: offset, bounds, store read ----------------
  logic [WORD_W-1:0] size_ext, boff, off;
  logic              direct, dvalid, fvalid, bvalid, lane_map;
  logic              b_v_q, b_map_q, map_flag_q;

  assign size_ext = WORD_W'(size_q);
  assign direct   = (fsize_q == '0) && (bsize_q == '0);
  assign dvalid   = a_ba_q < size_ext;
  assign fvalid   = a_fhit_q && (a_relf_q < size_ext);
  assign boff     = fsize_q + a_relb_q;
  // bank offset must not wrap past 2^32
  assign bvalid   = a_bhit_q && (boff >= fsize_q) && (boff < size_ext);
  assign lane_map = direct ? dvalid : (fvalid || bvalid);
  assign off      = direct ? a_ba_q : (fvalid ? a_relf_q : boff);

  always_ff @(posedge clk_i) begin
    if (a_v_q) begin
      b_map_q <= lane_map;
      if (a_first_q) begin
        map_flag_q <= lane_map;
      end
    end
  end

  // ---------------- ROM store ----------------
  logic          ram_en, ram_we;
  logic [AW-1:0] ram_addr;
  logic [BYTE_W-1:0] ram_rdata;

  assign ram_we   = cmd_i.write && (addr_q < DEPTH_W);
  assign ram_en   = ram_we || a_v_q;
  assign ram_addr = ram_we ? addr_q[AW-1:0] : off[AW-1:0];

  brmr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (ROM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (byte_q),
    .rdata_o (ram_rdata)
  );

  // ---------------- stage C: big-endian assembly ----------------
  logic [WORD_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      data_q <= '0;
    end else if (b_v_q && (func_e'(func_q) != FUNC_PROBE)) begin
      data_q <= {data_q[WORD_W-BYTE_W-1:0], b_map_q ? ram_rdata : 8'hFF};
    end
  end

  // ---------------- lane counters and pipeline valids ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= '0;
      idx_q <= '0;
      got_q <= '0;
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      a_v_q <= cmd_i.issue;
      b_v_q <= a_v_q;
      if (cmd_i.start) begin
        n_q   <= n_d;
        idx_q <= '0;
        got_q <= '0;
      end else begin
        if (cmd_i.issue) begin
          idx_q <= idx_q + CNT_W'(1);
        end
        if (b_v_q) begin
          got_q <= got_q + CNT_W'(1);
        end
      end
    end
  end

  // ---------------- output register ----------------
  logic              out_v_q;
  logic [WORD_W-1:0] out_data_q;
  logic              out_map_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_v_q <= 1'b1;
    end else if (m_tready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_data_q <= data_q;
      out_map_q  <= map_flag_q;
    end
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = {(M_TDATA_W-WORD_W-1)'(0), out_map_q, out_data_q};

  assign status_o.in_load    = (func_e'(in_func) == FUNC_LOAD);
  assign status_o.in_xfer    = in_xfer;
  assign status_o.issue_more = (idx_q < n_q);
  assign status_o.all_done   = (got_q == n_q);
  assign status_o.out_free   = !out_v_q || m_tready_i;

endmodule

// ===== src/brmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// brmr_ctrl
// Controller: takes requests, sequences store writes, byte lane issue and
// hand-over of the result to the output register.
// ----------------------------------------------------------------------------
module brmr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  brmr_pkg::dp_status_t status_i,
  output brmr_pkg::dp_cmd_t    cmd_o
);
  import brmr_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = s_tvalid_i && s_tready_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (status_i.in_load) begin
            state_d = ST_LOAD;
          end else if (status_i.in_xfer) begin
            state_d = ST_RUN;
          end
        end
      end
      ST_LOAD: state_d = ST_IDLE;
      ST_RUN: begin
        if (status_i.all_done) begin
          state_d = status_i.out_free ? ST_IDLE : ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o  = 1'b1;
        cmd_o.start = s_tvalid_i;
      end
      ST_LOAD: cmd_o.write = 1'b1;
      ST_RUN: begin
        cmd_o.issue   = status_i.issue_more;
        cmd_o.publish = status_i.all_done && status_i.out_free;
      end
      ST_FINISH: cmd_o.publish = status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/banked_rom_mapped_read_top.sv =====
// ----------------------------------------------------------------------------
// banked_rom_mapped_read_top
// Byte-wide ROM store, loaded byte by byte, read through a fixed/bank address
// map with big-endian 8, 16 and 32-bit reads.
// ----------------------------------------------------------------------------
// One request is handled at a time. A load writes the store in the load state
// before the next request is taken; an unused function code is dropped on
// acceptance. For a read or probe of N byte lanes (read8 and probe N=1, read16
// N=2, read32 N=4), one byte address enters the translation pipeline per
// cycle, and each lane passes a window compare stage, an offset/bounds stage
// that reads the single-port store, and an assembly stage. The result then
// sits in an output register, so the next request is taken while it waits to
// be collected. Each byte is translated on its own; an unmapped byte reads as
// 0xFF, and mapped reflects the first byte's address only. Bytes of the store
// that were never loaded read as undefined. The configuration port is not
// gated: write it only while no request is in flight.
// ----------------------------------------------------------------------------
module banked_rom_mapped_read_top #(
  parameter int unsigned ROM_DEPTH = brmr_pkg::ROM_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [brmr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [brmr_pkg::WORD_W-1:0]      cfg_data_i,
  // request stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [2:0] func, [34:3] address, [42:35] load_byte, [47:43] zero
  input  logic [brmr_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] read_data, [32] mapped, [39:33] zero
  output logic [brmr_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
  import brmr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  brmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  brmr_dp #(
    .ROM_DEPTH (ROM_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tdata_i   (s_axis_tdata),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// ===== tb/banked_rom_mapped_read_top_tb.sv =====
// ----------------------------------------------------------------------------
// banked_rom_mapped_read_top_tb
// Self-checking bench for the banked ROM mapped read block. Requests are
// packed onto the slave stream from a backlog queue. Each accepted request
// updates a shadow image of the store or predicts the read it causes. Results
// on the master stream are checked against the oldest prediction. The run
// steps through several window maps, from direct mapping to wrapping windows.
// It also varies the idle and stall patterns on both streams.
// ----------------------------------------------------------------------------
module banked_rom_mapped_read_top_tb;
  import brmr_pkg::*;

  localparam int unsigned STORE_DEPTH    = ROM_DEPTH_DEF;
  localparam int unsigned PHASES         = 14;
  localparam int unsigned ITEMS_PER_PHASE = 125;
  localparam int unsigned SETTLE_CYCLES  = 16;     // covers a load still in flight
  localparam int unsigned DRAIN_LIMIT    = 20000;
  localparam int unsigned CHOKE_LEN      = 300;    // long result hold-off
  localparam int unsigned READ_TRIES     = 8;
  // codes above probe are spare: no store change, no result
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 3'd5;

  // request fields, func in the low bits as on s_axis_tdata
  typedef struct packed {
    logic [BYTE_W-1:0] load_byte;
    logic [WORD_W-1:0] address;
    logic [FUNC_W-1:0] func;
  } rom_req_t;

  // result fields as on m_axis_tdata
  typedef struct packed {
    logic              mapped;
    logic [WORD_W-1:0] data;
  } rd_result_t;

  typedef struct packed {
    logic [WORD_W-1:0]   fix_base;
    logic [WORD_W-1:0]   fix_size;
    logic [WORD_W-1:0]   bank_base;
    logic [WORD_W-1:0]   bank_size;
    logic [LOADED_W-1:0] loaded;
  } rom_map_cfg_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [WORD_W-1:0]      cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata = '0;   // func, address, load_byte, zero pad
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;        // read_data, mapped, zero pad

  banked_rom_mapped_read_top #(
    .ROM_DEPTH(STORE_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow of the map registers, only changed while the block is idle
  logic [WORD_W-1:0]   cfg_fix_base  = '0;
  logic [WORD_W-1:0]   cfg_fix_size  = '0;
  logic [WORD_W-1:0]   cfg_bank_base = '0;
  logic [WORD_W-1:0]   cfg_bank_size = '0;
  logic [LOADED_W-1:0] cfg_loaded    = '0;

  // store image as seen by accepted loads, and what the backlog will have written
  logic [BYTE_W-1:0] rom_img [int unsigned];
  bit                rom_planned [int unsigned];
  int unsigned       planned_offs [$];

  rom_req_t    req_backlog [$];
  rd_result_t  expected_reads [$];
  bit          req_fire = 1'b0;
  int unsigned err_cnt = 0;

  int unsigned send_idle_pct = 0;
  int unsigned rsp_stall_pct = 0;
  bit          choke_rsp = 1'b0;
  int unsigned choke_cnt = 0;

  // --------------------------------------------------------------------------
  // Address map
  // --------------------------------------------------------------------------
  function automatic logic [WORD_W-1:0] eff_size();
    return (cfg_loaded < STORE_DEPTH) ? WORD_W'(cfg_loaded) : WORD_W'(STORE_DEPTH);
  endfunction

  // Direct map when both windows are off, else fixed window first, then bank.
  // A bank offset that wraps past 2^32 is refused.
  function automatic bit translate_addr(input logic [WORD_W-1:0] a,
                                        output logic [WORD_W-1:0] off);
    logic [WORD_W-1:0] sz;
    logic [WORD_W-1:0] rel;
    logic [WORD_W-1:0] o;
    sz  = eff_size();
    off = '0;
    if (cfg_fix_size == '0 && cfg_bank_size == '0) begin
      off = a;
      return a < sz;
    end
    if (cfg_fix_size != '0 && a >= cfg_fix_base) begin
      rel = a - cfg_fix_base;
      if (rel < cfg_fix_size && rel < sz) begin
        off = rel;
        return 1'b1;
      end
    end
    if (cfg_bank_size != '0 && a >= cfg_bank_base) begin
      rel = a - cfg_bank_base;
      if (rel < cfg_bank_size) begin
        o = cfg_fix_size + rel;
        if (o >= cfg_fix_size && o < sz) begin
          off = o;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic int unsigned lane_count(logic [FUNC_W-1:0] f);
    case (f)
      FUNC_READ8:  return 1;
      FUNC_READ16: return 2;
      FUNC_READ32: return 4;
      default:     return 0;
    endcase
  endfunction

  // Big-endian assembly, lanes translated one by one, unmapped lane = 0xFF.
  // Mapped flag comes from the first address only; probe data stays zero.
  function automatic rd_result_t predict_read(logic [FUNC_W-1:0] f,
                                              logic [WORD_W-1:0] a);
    rd_result_t        r;
    logic [WORD_W-1:0] off;
    logic [BYTE_W-1:0] b;
    r.mapped = translate_addr(a, off);
    r.data   = '0;
    for (int unsigned i = 0; i < lane_count(f); i++) begin
      b = 8'hFF;
      if (translate_addr(a + WORD_W'(i), off))
        b = rom_img.exists(off) ? rom_img[off] : 8'h00;
      r.data = {r.data[WORD_W-BYTE_W-1:0], b};
    end
    return r;
  endfunction

  // A read must never land on a store byte that no load has written.
  function automatic bit read_is_safe(logic [FUNC_W-1:0] f, logic [WORD_W-1:0] a);
    logic [WORD_W-1:0] off;
    for (int unsigned i = 0; i < lane_count(f); i++)
      if (translate_addr(a + WORD_W'(i), off) && !rom_planned.exists(off))
        return 1'b0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_req(logic [FUNC_W-1:0] f, logic [WORD_W-1:0] a,
                          logic [BYTE_W-1:0] b);
    rom_req_t rq;
    rq.func      = f;
    rq.address   = a;
    rq.load_byte = b;
    req_backlog.push_back(rq);
    if (f == FUNC_LOAD && a < STORE_DEPTH && !rom_planned.exists(a)) begin
      rom_planned[a] = 1'b1;
      planned_offs.push_back(a);
    end
  endtask

  // Mostly aim at loaded bytes through the inverse map, else window edges
  // or anything at all.
  function automatic logic [WORD_W-1:0] pick_addr();
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] off;
    logic [WORD_W-1:0] bounds [12];
    case ($urandom_range(9))
      5: begin
        bounds = '{cfg_fix_base, cfg_fix_base - 1, cfg_fix_base + cfg_fix_size - 1,
                   cfg_fix_base + cfg_fix_size, cfg_bank_base, cfg_bank_base - 1,
                   cfg_bank_base + cfg_bank_size - 1, cfg_bank_base + cfg_bank_size,
                   eff_size() - 1, eff_size(), 32'h0, 32'hFFFF_FFFF};
        a = bounds[$urandom_range(11)] - $urandom_range(3);
      end
      6: a = $urandom;
      7: a = $urandom_range(2 * eff_size() + 16);
      default: begin
        off = planned_offs[$urandom_range(planned_offs.size() - 1)];
        if (cfg_fix_size == '0 && cfg_bank_size == '0) a = off;
        else if (off < cfg_fix_size) a = cfg_fix_base + off;
        else a = cfg_bank_base + (off - cfg_fix_size);
        if ($urandom_range(3) == 0) a = a + $urandom_range(6) - 3;
      end
    endcase
    return a;
  endfunction

  // Load runs of a few bytes, reads into them, and some noise
  task automatic gen_traffic(int unsigned n);
    int unsigned       left;
    int unsigned       len;
    int unsigned       lim;
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] a;
    logic [FUNC_W-1:0] f;
    bit                ok;
    left = n;
    lim  = (eff_size() > 16) ? eff_size() - 1 : 255;
    while (left > 0) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4: begin
          len = $urandom_range(16, 4);
          if (len > left) len = left;
          case ($urandom_range(9))
            0, 1, 2, 3, 4: base = $urandom_range(lim < 1023 ? lim : 1023);
            9:             base = STORE_DEPTH - 8 + $urandom_range(15);  // across the top
            default:       base = $urandom_range(lim);
          endcase
          for (int unsigned i = 0; i < len; i++)
            push_req(FUNC_LOAD, base + i, BYTE_W'($urandom_range(255)));
          left -= len;
        end
        5: begin
          if ($urandom_range(1) == 0)
            push_req(FUNC_SPARE + FUNC_W'($urandom_range(2)), $urandom,
                     BYTE_W'($urandom_range(255)));
          else
            push_req(FUNC_LOAD, $urandom, BYTE_W'($urandom_range(255)));
          left--;
        end
        default: begin
          f  = FUNC_READ8 + FUNC_W'($urandom_range(3));
          ok = 1'b0;
          a  = '0;
          for (int unsigned t = 0; t < READ_TRIES && !ok; t++) begin
            a  = pick_addr();
            ok = read_is_safe(f, a);
          end
          push_req(ok ? f : FUNC_PROBE, a, BYTE_W'($urandom_range(255)));
          left--;
        end
      endcase
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [WORD_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_FIXED_BASE: cfg_fix_base  = val;
      CFG_FIXED_SIZE: cfg_fix_size  = val;
      CFG_BANK_BASE:  cfg_bank_base = val;
      CFG_BANK_SIZE:  cfg_bank_size = val;
      CFG_LOADED:     cfg_loaded    = val[LOADED_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(rom_map_cfg_t c);
    write_reg(CFG_FIXED_BASE, c.fix_base);
    write_reg(CFG_FIXED_SIZE, c.fix_size);
    write_reg(CFG_BANK_BASE,  c.bank_base);
    write_reg(CFG_BANK_SIZE,  c.bank_size);
    write_reg(CFG_LOADED,     WORD_W'(c.loaded));
  endtask

  function automatic logic [WORD_W-1:0] pick_word(int unsigned span);
    case ($urandom_range(4))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF - $urandom_range(span);
      2:       return $urandom;
      default: return $urandom_range(span, 1);
    endcase
  endfunction

  // Hand-picked maps first, then random ones
  function automatic rom_map_cfg_t phase_cfg(int unsigned p);
    case (p)
      // direct map, bases ignored
      0: return '{32'h1111_0000, 32'h0, 32'h2222_0000, 32'h0, 21'd1024};
      // fixed window only, bounded by the loaded size
      1: return '{32'h0001_0000, 32'h800, 32'h0, 32'h0, 21'h600};
      // both windows, bank partly beyond the loaded size
      2: return '{32'h0, 32'h100, 32'h0020_0000, 32'h400, 21'h400};
      // direct map, loaded size beyond the store
      3: return '{32'h0, 32'h0, 32'h0, 32'h0, 21'h1F_FFFF};
      // bank at the top of the bus, wide reads wrap into the fixed window
      4: return '{32'h0, 32'h10, 32'hFFFF_FF00, 32'hFFFF_FFFF, LOADED_W'(STORE_DEPTH)};
      // bank offsets wrap past 2^32 and must be refused
      5: return '{32'h8000_0000, 32'hFFFF_FF80, 32'h1000, 32'h1000, LOADED_W'(STORE_DEPTH)};
      // all-ones sizes
      6: return '{32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 21'h1F_FFFF};
      // bank window only
      7: return '{32'hFFFF_FFFF, 32'h0, 32'h4000_0000, 32'h2000, 21'h3000};
      // windows on, nothing loaded
      8: return '{32'h0, 32'h100, 32'h100, 32'h100, 21'd0};
      default: begin
        rom_map_cfg_t c;
        c.fix_base  = pick_word(16'hFFFF);
        c.fix_size  = pick_word(2048);
        c.bank_base = pick_word(16'hFFFF);
        c.bank_size = pick_word(2048);
        case ($urandom_range(4))
          0:       c.loaded = '0;
          1:       c.loaded = LOADED_W'(STORE_DEPTH);
          2:       c.loaded = '1;
          default: c.loaded = LOADED_W'($urandom_range(4096));
        endcase
        return c;
      end
    endcase
  endfunction

  // Backlog and every prediction drained, then a settling wait for a late load
  task automatic wait_idle();
    int unsigned guard;
    guard = 0;
    while ((req_backlog.size() != 0 || s_axis_tvalid || expected_reads.size() != 0)
           && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    if (guard >= DRAIN_LIMIT) begin
      $error("results outstanding after drain: %0d", expected_reads.size());
      err_cnt++;
      expected_reads.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Request driver: holds a request until taken, then offers the next one or
  // idles by the current sender idle rate.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_req
    logic [S_TDATA_W-1:0] word;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_fire) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        word = '0;
        word[$bits(rom_req_t)-1:0] = req_backlog.pop_front();
        s_axis_tdata  <= word;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result sink: random stalls, plus one long hold-off while choke is armed
  always @(negedge clk_i) begin : drive_rsp_ready
    m_axis_tready <= !(choke_rsp && choke_cnt < CHOKE_LEN)
                     && ($urandom_range(99) >= rsp_stall_pct);
  end

  always @(posedge clk_i) begin : choke_timer
    if (choke_rsp && choke_cnt < CHOKE_LEN) choke_cnt <= choke_cnt + 1;
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each accepted request, check each collected result
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    rom_req_t   rq;
    rd_result_t got;
    rd_result_t want;
    req_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    if (req_fire) begin
      rq = s_axis_tdata[$bits(rom_req_t)-1:0];
      if (rq.func == FUNC_LOAD) begin
        if (rq.address < STORE_DEPTH) rom_img[rq.address] = rq.load_byte;
      end else if (rq.func <= FUNC_PROBE) begin
        expected_reads.push_back(predict_read(rq.func, rq.address));
      end
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(rd_result_t)-1:0];
      if (expected_reads.size() == 0) begin
        $error("result with none outstanding: read_data=%h mapped=%b", got.data, got.mapped);
        err_cnt++;
      end else begin
        want = expected_reads.pop_front();
        if (got.data !== want.data) begin
          $error("read_data: expected %h, got %h", want.data, got.data);
          err_cnt++;
        end
        if (got.mapped !== want.mapped) begin
          $error("mapped: expected %b, got %b", want.mapped, got.mapped);
          err_cnt++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // All registers at reset: nothing loaded, so every read is unmapped
    push_req(FUNC_READ8, 32'h0, 8'h00);
    push_req(FUNC_PROBE, 32'hFFFF_FFFF, 8'hFF);
    push_req(FUNC_READ32, 32'h0, 8'h00);
    push_req(FUNC_LOAD, 32'd0, 8'h00);
    push_req(FUNC_LOAD, 32'd1, 8'hFF);
    push_req(FUNC_LOAD, 32'd2, 8'h5A);
    push_req(FUNC_LOAD, 32'd3, 8'hA5);
    push_req(FUNC_LOAD, 32'd4, 8'h01);
    push_req(FUNC_LOAD, 32'd5, 8'h80);
    push_req(FUNC_LOAD, 32'd6, 8'h7F);
    push_req(FUNC_LOAD, 32'd7, 8'hFE);
    for (int unsigned i = 4; i >= 1; i--)
      push_req(FUNC_LOAD, STORE_DEPTH - i, BYTE_W'($urandom_range(255)));
    // loads beyond the store are dropped
    push_req(FUNC_LOAD, STORE_DEPTH, 8'hC3);
    push_req(FUNC_LOAD, 32'hFFFF_FFFF, 8'h3C);
    for (int unsigned i = 0; i < 3; i++)
      push_req(FUNC_SPARE + FUNC_W'(i), $urandom, BYTE_W'($urandom_range(255)));
    wait_idle();

    // Direct map over the eight bytes just loaded
    apply_cfg('{32'h0, 32'h0, 32'h0, 32'h0, 21'd8});
    push_req(FUNC_READ8, 32'd0, 8'h00);
    push_req(FUNC_READ16, 32'd6, 8'h00);
    push_req(FUNC_READ32, 32'd4, 8'h00);
    push_req(FUNC_READ32, 32'd6, 8'h00);           // upper lanes past the loaded size
    push_req(FUNC_READ32, 32'hFFFF_FFFE, 8'h00);   // lane addresses wrap to 0 and 1
    push_req(FUNC_PROBE, 32'd7, 8'h00);
    push_req(FUNC_PROBE, 32'd8, 8'h00);
    wait_idle();

    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin send_idle_pct = 54; rsp_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rsp_stall_pct = 54; end
        default: begin send_idle_pct = 26; rsp_stall_pct = 26; end
      endcase
      apply_cfg(phase_cfg(p));
      // sender keeps pushing while results are held back, so the block backs up
      if (p == 2) choke_rsp = 1'b1;
      if (p == 3) begin
        // top of the store, upper lanes fall off the end
        push_req(FUNC_READ32, STORE_DEPTH - 2, 8'h00);
        push_req(FUNC_READ16, STORE_DEPTH - 1, 8'h00);
        push_req(FUNC_READ8, STORE_DEPTH - 1, 8'h00);
        push_req(FUNC_PROBE, STORE_DEPTH, 8'h00);
      end
      gen_traffic(ITEMS_PER_PHASE);
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("banked_rom_mapped_read_top_tb passed");
    end else begin
      $display("banked_rom_mapped_read_top_tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("banked_rom_mapped_read_top_tb failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/brmr_pkg.sv
src/brmr_ram.sv
src/brmr_dp.sv
src/brmr_ctrl.sv
src/banked_rom_mapped_read_top.sv
tb/banked_rom_mapped_read_top_tb.sv
